// ===== sv/iso_ms_pkg.sv =====
package iso_ms_pkg;

  // Default number of fraction digits kept toward the millisecond value.
  localparam int MS_DIGITS_DEF = 3;

  // Character codes seen by the parser.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Which field of the timestamp the parser is working on.
  typedef enum logic [3:0] {
    PH_YEAR,
    PH_MONTH,
    PH_DAY,
    PH_HOUR,
    PH_MINUTE,
    PH_SECOND,
    PH_FRACTION,
    PH_IGNORE
  } field_phase_t;

  // Controller states: parsing, one state per arithmetic stage, then a finish state.
  typedef enum logic [2:0] {
    ST_PARSE,
    ST_ERA,
    ST_YOE,
    ST_DOE,
    ST_DAYS,
    ST_DSEC,
    ST_SECS,
    ST_FINISH
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;    // a character word is accepted this cycle
    logic finish;  // load the result register and clear the parser
  } iso_ms_cmd_t;

  // Separator that must close the given date or time field.
  function automatic logic [7:0] sep_char(field_phase_t ph);
    logic [7:0] c;
    unique case (ph)
      PH_YEAR, PH_MONTH: c = CH_DASH;
      PH_DAY:            c = CH_T;
      default:           c = CH_COLON;
    endcase
    return c;
  endfunction

  // Scale that pads the kept fraction digits out to milliseconds.
  function automatic logic [9:0] ms_scale(logic [1:0] kept);
    logic [9:0] s;
    unique case (kept)
      2'd0:    s = 10'd1000;
      2'd1:    s = 10'd100;
      2'd2:    s = 10'd10;
      default: s = 10'd1;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/iso_ms_ctrl.sv =====
module iso_ms_ctrl import iso_ms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  input  logic        last_char,
  input  logic        result_stall,
  output logic        char_stall,
  output logic        result_valid,
  output iso_ms_cmd_t cmd
);

  ctl_state_t state;
  ctl_state_t state_next;
  logic       result_valid_next;
  logic       out_free;

  // State and result flag registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_PARSE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // The result register can take a new word when empty or being emptied.
  assign out_free = !result_valid || !result_stall;

  // Next state, commands and handshake outputs.
  always_comb begin
    state_next = state;
    char_stall = (state != ST_PARSE);
    cmd.take   = (state == ST_PARSE) && char_valid;
    cmd.finish = (state == ST_FINISH) && out_free;

    unique case (state)
      ST_PARSE: begin
        if (char_valid && last_char) begin
          state_next = ST_ERA;
        end
      end
      ST_ERA:  state_next = ST_YOE;
      ST_YOE:  state_next = ST_DOE;
      ST_DOE:  state_next = ST_DAYS;
      ST_DAYS: state_next = ST_DSEC;
      ST_DSEC: state_next = ST_SECS;
      ST_SECS: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_PARSE;
        end
      end
      default: state_next = ST_PARSE;
    endcase

    // A new result sets the flag; a taken result clears it.
    if (cmd.finish) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

endmodule

// ===== sv/iso_ms_dp.sv =====
module iso_ms_dp import iso_ms_pkg::*; #(
  parameter int MS_DIGITS = MS_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         char_code,
  input  iso_ms_cmd_t        cmd,
  output logic signed [48:0] epoch_ms,
  output logic               parse_ok
);

  // Reciprocals for the constant divisions by 400 and by 5.
  localparam logic [12:0] ERA_RECIP   = 13'd5243;
  localparam logic [13:0] DIV5_RECIP  = 14'd13108;

  // Parser state.
  field_phase_t phase, phase_next;
  logic [2:0]   digit_count, digit_count_next;
  logic [13:0]  year_acc, year_acc_next;
  logic [6:0]   month_acc, month_acc_next;
  logic [6:0]   day_acc, day_acc_next;
  logic [6:0]   hour_acc, hour_acc_next;
  logic [6:0]   minute_acc, minute_acc_next;
  logic [6:0]   second_acc, second_acc_next;
  logic [9:0]   fraction_acc, fraction_acc_next;
  logic [1:0]   fraction_digits_kept, fraction_digits_kept_next;
  logic         format_error, format_error_next;

  logic         is_digit;
  logic [3:0]   digit_value;
  logic [13:0]  acc_sel;
  logic [13:0]  acc_mac;
  logic [9:0]   frac_mac;
  logic [2:0]   max_digits;
  logic         write_acc;
  logic         ok_now;

  // Character classification and the multiply-by-ten accumulate.
  assign is_digit    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digit_value = is_digit ? char_code[3:0] : 4'd0;
  assign max_digits  = (phase == PH_YEAR) ? 3'd4 : 3'd2;

  always_comb begin
    unique case (phase)
      PH_YEAR:   acc_sel = year_acc;
      PH_MONTH:  acc_sel = {7'b0, month_acc};
      PH_DAY:    acc_sel = {7'b0, day_acc};
      PH_HOUR:   acc_sel = {7'b0, hour_acc};
      PH_MINUTE: acc_sel = {7'b0, minute_acc};
      default:   acc_sel = {7'b0, second_acc};
    endcase
  end

  assign acc_mac  = {acc_sel[10:0], 3'b0} + {acc_sel[12:0], 1'b0} + {10'b0, digit_value};
  assign frac_mac = {fraction_acc[6:0], 3'b0} + {fraction_acc[8:0], 1'b0}
                  + {6'b0, digit_value};

  // Parser next state for one character word.
  always_comb begin
    phase_next                = phase;
    digit_count_next          = digit_count;
    year_acc_next             = year_acc;
    month_acc_next            = month_acc;
    day_acc_next              = day_acc;
    hour_acc_next             = hour_acc;
    minute_acc_next           = minute_acc;
    second_acc_next           = second_acc;
    fraction_acc_next         = fraction_acc;
    fraction_digits_kept_next = fraction_digits_kept;
    format_error_next         = format_error;
    write_acc                 = 1'b0;

    if (cmd.take && !format_error) begin
      unique case (phase)
        PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE: begin
          if (is_digit) begin
            if (digit_count < max_digits) begin
              write_acc        = 1'b1;
              digit_count_next = digit_count + 3'd1;
            end else begin
              format_error_next = 1'b1;
            end
          end else if ((digit_count != 3'd0) && (char_code == sep_char(phase))) begin
            phase_next       = field_phase_t'(phase + 4'd1);
            digit_count_next = 3'd0;
          end else begin
            format_error_next = 1'b1;
          end
        end
        PH_SECOND: begin
          // A third seconds digit ends the seconds like any other tail.
          if (is_digit && (digit_count < 3'd2)) begin
            write_acc        = 1'b1;
            digit_count_next = digit_count + 3'd1;
          end else if (digit_count == 3'd0) begin
            format_error_next = 1'b1;
          end else if (char_code == CH_DOT) begin
            phase_next       = PH_FRACTION;
            digit_count_next = 3'd0;
          end else begin
            phase_next = PH_IGNORE;
          end
        end
        PH_FRACTION: begin
          if (is_digit) begin
            if (fraction_digits_kept < 2'(MS_DIGITS)) begin
              fraction_acc_next         = frac_mac;
              fraction_digits_kept_next = fraction_digits_kept + 2'd1;
            end
          end else begin
            phase_next = PH_IGNORE;
          end
        end
        default: begin
        end
      endcase
    end

    // Write the accumulated digit into the field being parsed.
    if (write_acc) begin
      unique case (phase)
        PH_YEAR:   year_acc_next   = acc_mac;
        PH_MONTH:  month_acc_next  = acc_mac[6:0];
        PH_DAY:    day_acc_next    = acc_mac[6:0];
        PH_HOUR:   hour_acc_next   = acc_mac[6:0];
        PH_MINUTE: minute_acc_next = acc_mac[6:0];
        default:   second_acc_next = acc_mac[6:0];
      endcase
    end

    // Once the result is loaded the parser starts over.
    if (cmd.finish) begin
      phase_next                = PH_YEAR;
      digit_count_next          = 3'd0;
      year_acc_next             = 14'd0;
      month_acc_next            = 7'd0;
      day_acc_next              = 7'd0;
      hour_acc_next             = 7'd0;
      minute_acc_next           = 7'd0;
      second_acc_next           = 7'd0;
      fraction_acc_next         = 10'd0;
      fraction_digits_kept_next = 2'd0;
      format_error_next         = 1'b0;
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_YEAR;
      digit_count          <= 3'd0;
      year_acc             <= 14'd0;
      month_acc            <= 7'd0;
      day_acc              <= 7'd0;
      hour_acc             <= 7'd0;
      minute_acc           <= 7'd0;
      second_acc           <= 7'd0;
      fraction_acc         <= 10'd0;
      fraction_digits_kept <= 2'd0;
      format_error         <= 1'b0;
    end else begin
      phase                <= phase_next;
      digit_count          <= digit_count_next;
      year_acc             <= year_acc_next;
      month_acc            <= month_acc_next;
      day_acc              <= day_acc_next;
      hour_acc             <= hour_acc_next;
      minute_acc           <= minute_acc_next;
      second_acc           <= second_acc_next;
      fraction_acc         <= fraction_acc_next;
      fraction_digits_kept <= fraction_digits_kept_next;
      format_error         <= format_error_next;
    end
  end

  // The text matched when at least one seconds digit was seen without error.
  assign ok_now = !format_error &&
                  (((phase == PH_SECOND) && (digit_count != 3'd0)) ||
                   (phase == PH_FRACTION) || (phase == PH_IGNORE));

  // Stage 1: shifted year, era by reciprocal, month term, ms and time of day.
  logic               mon_le2;
  logic signed [14:0] yr;
  logic [25:0]        era_prod;
  logic signed [5:0]  era_c;
  logic [6:0]         mp;
  logic [13:0]        t_c;
  logic [19:0]        ms_prod;
  logic [18:0]        hms_c;

  assign mon_le2  = (month_acc <= 7'd2);
  assign yr       = $signed({1'b0, year_acc}) - $signed({14'b0, mon_le2});
  assign era_prod = 26'(yr[13:0]) * 26'(ERA_RECIP);
  assign era_c    = yr[14] ? -6'sd1 : $signed({1'b0, era_prod[25:21]});
  assign mp       = mon_le2 ? (month_acc + 7'd9) : (month_acc - 7'd3);
  assign t_c      = ({7'b0, mp} * 14'd153) + 14'd2;
  assign ms_prod  = {10'b0, fraction_acc} * {10'b0, ms_scale(fraction_digits_kept)};
  assign hms_c    = ({12'b0, hour_acc} * 19'd3600) + ({12'b0, minute_acc} * 19'd60)
                  + {12'b0, second_acc};

  logic signed [14:0] s1_yr;
  logic signed [5:0]  s1_era;
  logic [13:0]        s1_t;
  logic [9:0]         s1_ms;
  logic [18:0]        s1_hms;

  // Stage 2: year of era and day of year.
  logic signed [15:0] era400;
  logic signed [15:0] yoe_w;
  logic [27:0]        div5_prod;
  logic signed [12:0] doy_c;

  assign era400    = $signed({{10{s1_era[5]}}, s1_era}) * 16'sd400;
  assign yoe_w     = $signed({s1_yr[14], s1_yr}) - era400;
  assign div5_prod = 28'(s1_t) * 28'(DIV5_RECIP);
  assign doy_c     = $signed({1'b0, div5_prod[27:16]}) + $signed({6'b0, day_acc}) - 13'sd1;

  logic [8:0]         s2_yoe;
  logic signed [12:0] s2_doy;

  // Stage 3: day of era and the era offset in days.
  logic [17:0]        yoe365;
  logic [1:0]         cent;
  logic signed [18:0] doe_c;
  logic signed [23:0] erad_c;

  assign yoe365 = 18'(s2_yoe) * 18'd365;

  always_comb begin
    priority if (s2_yoe >= 9'd300) begin
      cent = 2'd3;
    end else if (s2_yoe >= 9'd200) begin
      cent = 2'd2;
    end else if (s2_yoe >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
  end

  assign doe_c  = $signed({1'b0, yoe365}) + $signed({12'b0, s2_yoe[8:2]})
                - $signed({17'b0, cent}) + $signed({{6{s2_doy[12]}}, s2_doy});
  assign erad_c = $signed({{18{s1_era[5]}}, s1_era}) * 24'sd146097;

  logic signed [18:0] s3_doe;
  logic signed [23:0] s3_erad;

  // Stage 4: days since the epoch; stage 5: seconds of those days.
  logic signed [23:0] s4_days;
  logic signed [39:0] s5_dsec;
  logic signed [39:0] s6_secs;

  // Final step: seconds times 1000 as shifts, plus the milliseconds.
  logic [48:0] sx;
  logic [48:0] total;

  assign sx    = {{9{s6_secs[39]}}, s6_secs};
  assign total = {sx[38:0], 10'b0} - {sx[44:0], 4'b0} - {sx[45:0], 3'b0} + {39'b0, s1_ms};

  // Arithmetic stage registers run every cycle; the controller counts the depth.
  always_ff @(posedge clk) begin
    s1_yr   <= yr;
    s1_era  <= era_c;
    s1_t    <= t_c;
    s1_ms   <= ms_prod[9:0];
    s1_hms  <= hms_c;
    s2_yoe  <= yoe_w[8:0];
    s2_doy  <= doy_c;
    s3_doe  <= doe_c;
    s3_erad <= erad_c;
    s4_days <= s3_erad + $signed({{5{s3_doe[18]}}, s3_doe}) - 24'sd719468;
    s5_dsec <= $signed({{16{s4_days[23]}}, s4_days}) * 40'sd86400;
    s6_secs <= s5_dsec + $signed({21'b0, s1_hms});
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      epoch_ms <= ok_now ? $signed(total) : 49'sd0;
      parse_ok <= ok_now;
    end
  end

endmodule

// ===== sv/iso8601_timestamp_to_epoch_ms.sv =====
// Converts an ISO-8601 UTC timestamp of the form YYYY-MM-DDTHH:MM:SS[.fff], sent one
// character word per cycle with last_char on the final one, into signed milliseconds
// since 1970-01-01T00:00:00Z and a parse_ok flag; epoch_ms is zero when parse_ok is
// clear. Characters are taken at one per cycle while char_stall is low. After the last
// character, char_stall stays high while a six-stage arithmetic pipeline (era by
// reciprocal, year of era, day of era, day count, seconds of those days, total seconds)
// and a final milliseconds step produce the result. The result sits in an output
// register; if that register is still full the block holds until the word is taken.
module iso8601_timestamp_to_epoch_ms import iso_ms_pkg::*; #(
  parameter int MS_DIGITS = MS_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [7:0]         char_code,
  input  logic               last_char,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [48:0] epoch_ms,
  output logic               parse_ok
);

  iso_ms_cmd_t cmd;

  // Sequencer for parsing and the arithmetic pipeline.
  iso_ms_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .last_char    (last_char),
    .result_stall (result_stall),
    .char_stall   (char_stall),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  // Parser, date arithmetic and result register.
  iso_ms_dp #(
    .MS_DIGITS (MS_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .cmd       (cmd),
    .epoch_ms  (epoch_ms),
    .parse_ok  (parse_ok)
  );

  // A failed parse always reports zero milliseconds.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !parse_ok) |-> (epoch_ms == 49'sd0))
    else $error("invalid result carries a nonzero epoch value");

  // The last character of a timestamp holds off further characters.
  assert property (@(posedge clk) disable iff (rst)
    (char_valid && !char_stall && last_char) |=> char_stall)
    else $error("character accepted while the result is being computed");

  // A new result appears only at the end of a computation.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(char_stall))
    else $error("result raised without a finished computation");

endmodule
